// ----- rtl/vnce_pkg.sv -----
// shared constants, types and helpers for the voxel neighbor cost expander
// used by vnce_div and the top level; no dependencies
`timescale 1ns / 1ps

package vnce_pkg;

   // voxel store
   localparam int VOXEL_DEPTH = 65536;
   localparam int VOXEL_AW    = $clog2(VOXEL_DEPTH);

   // field widths
   localparam int ID_W   = 16;
   localparam int GRID_W = 9;
   localparam int CMIN_W = 15;
   localparam int CLR_W  = 16;
   localparam int CSR_W  = 15;
   localparam int COST_W = 16;
   localparam int STEP_W = 9;

   // derived arithmetic widths
   localparam int SXY_W = 2 * GRID_W;
   localparam int TOT_W = 3 * GRID_W;
   localparam int LID_W = SXY_W + 3;   // signed neighbor id before the range test
   localparam int NUM_W = STEP_W + 8;
   localparam int DEN_W = CLR_W - 1;
   localparam int ENT_W = CLR_W + 1;   // store entry: reachable flag over clearance

   localparam logic [TOT_W-1:0]  DEPTH_LIM = TOT_W'(VOXEL_DEPTH);
   localparam logic [COST_W-1:0] COST_MAX  = '1;

   // commands
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_EXPAND = 1'b1;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_X   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Y   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Z   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLR_MIN  = 2'd3;

   localparam logic [GRID_W-1:0] GRID_RESET = 9'd32;
   localparam logic [CMIN_W-1:0] CMIN_RESET = 15'd49;   // about 0.19 in Q8.8

   // per-axis offset codes
   localparam logic [1:0] OFS_NEG = 2'd0;
   localparam logic [1:0] OFS_MID = 2'd1;
   localparam logic [1:0] OFS_POS = 2'd2;

   // step lengths in Q8.8
   localparam logic [STEP_W-1:0] STEP_ONE   = 9'd256;
   localparam logic [STEP_W-1:0] STEP_TWO   = 9'd362;
   localparam logic [STEP_W-1:0] STEP_THREE = 9'd443;

   typedef struct packed {
      logic [ID_W-1:0] nid;
      logic            acc;
      logic            last;
   } side_type;

   // dividend: step length scaled by 256, by count of nonzero offsets
   function automatic logic [NUM_W-1:0] step_num(input logic [1:0] nz);
      logic [STEP_W-1:0] step;
      case (nz)
         2'd2:    step = STEP_TWO;
         2'd3:    step = STEP_THREE;
         default: step = STEP_ONE;
      endcase
      return {step, 8'h00};
   endfunction

endpackage

// ----- rtl/vnce_ram.sv -----
// generic synchronous ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module vnce_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/vnce_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with sideband
// depends on vnce_pkg
`timescale 1ns / 1ps

module vnce_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic [vnce_pkg::NUM_W-1:0] in_num,
   input  logic [vnce_pkg::DEN_W-1:0] in_den,
   input  vnce_pkg::side_type         in_side,
   output logic                       out_valid,
   output logic [vnce_pkg::NUM_W-1:0] out_quo,
   output vnce_pkg::side_type         out_side
);

   import vnce_pkg::*;

   logic [NUM_W:0]     vld_ff;
   logic [DEN_W-1:0]   rem_ff  [0:NUM_W];
   logic [NUM_W-1:0]   q_ff    [0:NUM_W];
   logic [DEN_W-1:0]   den_ff  [0:NUM_W];
   side_type           side_ff [0:NUM_W];

   logic [DEN_W:0]     trial   [1:NUM_W];
   logic [DEN_W-1:0]   rem_in  [1:NUM_W];
   logic [NUM_W-1:0]   q_in    [1:NUM_W];

   // q holds the unused dividend bits on top and the quotient bits below
   always_comb begin
      for (int k = 1; k <= NUM_W; k++) begin
         trial[k] = {rem_ff[k-1], q_ff[k-1][NUM_W-1]};
         if (trial[k] >= {1'b0, den_ff[k-1]}) begin
            rem_in[k] = DEN_W'(trial[k] - {1'b0, den_ff[k-1]});
            q_in[k]   = {q_ff[k-1][NUM_W-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[k][DEN_W-1:0];
            q_in[k]   = {q_ff[k-1][NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NUM_W-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= '0;
         q_ff[0]    <= in_num;
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         for (int k = 1; k <= NUM_W; k++) begin
            rem_ff[k]  <= rem_in[k];
            q_ff[k]    <= q_in[k];
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = vld_ff[NUM_W];
   assign out_quo   = q_ff[NUM_W];
   assign out_side  = side_ff[NUM_W];

endmodule

// ----- rtl/voxel_neighbor_cost_expander_unit.sv -----
// top level: request handling, neighbor walk, store lookup and result register
// depends on vnce_pkg, vnce_ram and vnce_div
`timescale 1ns / 1ps

// A load item writes one voxel entry (reachable flag and Q8.8 clearance) into a
// 64K x 17 synchronous store. An expand item steps the sequencer through the
// grid plane and volume sizes, formed with one multiplier each, then through
// each of the 27 offset positions, the center being an empty slot. The address
// and store read stages drain before the next item is taken. Neighbor results
// leave in walk order, behind the pipelined divider that forms step length
// over clearance and takes a new neighbor while earlier ones are in flight.
// A stalled result holds the whole lookup and divide pipeline. The store has
// no reset; expanding onto an entry that was never loaded gives undefined
// results for that neighbor.
module voxel_neighbor_cost_expander_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_cmd,
   input  logic [vnce_pkg::ID_W-1:0]      req_voxel_id,
   input  logic                           req_reachable_in,
   input  logic signed [vnce_pkg::CLR_W-1:0] req_clearance_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [vnce_pkg::ID_W-1:0]      rsp_neighbor_id,
   output logic [vnce_pkg::COST_W-1:0]    rsp_step_cost,
   output logic                           rsp_accepted,
   output logic                           rsp_last,
   input  logic                           csr_wr_en,
   input  logic [vnce_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [vnce_pkg::CSR_W-1:0]     csr_wr_data
);

   import vnce_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SXY  = 2'd1;
   localparam logic [1:0] S_TOT  = 2'd2;
   localparam logic [1:0] S_WALK = 2'd3;

   // configuration
   logic [GRID_W-1:0] grid_x_ff, grid_y_ff, grid_z_ff;
   logic [CMIN_W-1:0] cmin_ff;

   // sequencer
   logic [1:0]        state_ff, state_in;
   logic [1:0]        ox_ff, oy_ff, oz_ff, ox_in, oy_in, oz_in;
   logic [ID_W-1:0]   center_ff;
   logic [SXY_W-1:0]  sxy_ff;
   logic [TOT_W-1:0]  total_ff;

   // address stage
   logic              s1_valid_ff, s1_last_ff;
   logic signed [LID_W-1:0] s1_id_ff;
   logic [1:0]        s1_nz_ff;

   // store read stage
   logic              s2_valid_ff, s2_inr_ff, s2_last_ff;
   logic [ID_W-1:0]   s2_nid_ff;
   logic [1:0]        s2_nz_ff;

   // result register
   logic              rsp_valid_ff, rsp_acc_ff, rsp_last_ff;
   logic [ID_W-1:0]   rsp_nid_ff;
   logic [COST_W-1:0] rsp_cost_ff;

   logic              adv, req_fire, issue, at_center, at_end, s1_inr;
   logic signed [LID_W-1:0] center_s, sx_s, sxy_s, tx, ty, tz, id_sum;
   logic [1:0]        nz_cur;

   logic              ram_wr_en;
   logic [VOXEL_AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [ENT_W-1:0]  ram_wr_data, ram_rd_data;

   logic [CLR_W-1:0]  s2_clr;
   logic              s2_acc;
   side_type          div_side_in, div_side_out;
   logic              div_valid;
   logic [NUM_W-1:0]  div_quo;
   logic [COST_W-1:0] cost_sat;

   // the whole pipeline holds while a result waits
   assign adv       = !(rsp_valid_ff && !rsp_ready);
   assign req_ready = (state_ff == S_IDLE) && !s1_valid_ff && !s2_valid_ff;
   assign req_fire  = req_valid && req_ready;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_x_ff <= GRID_RESET;
         grid_y_ff <= GRID_RESET;
         grid_z_ff <= GRID_RESET;
         cmin_ff   <= CMIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_X:  grid_x_ff <= csr_wr_data[GRID_W-1:0];
            CSR_GRID_Y:  grid_y_ff <= csr_wr_data[GRID_W-1:0];
            CSR_GRID_Z:  grid_z_ff <= csr_wr_data[GRID_W-1:0];
            CSR_CLR_MIN: cmin_ff   <= csr_wr_data[CMIN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- neighbor walk ----------------
   assign at_center = (ox_ff == OFS_MID) && (oy_ff == OFS_MID) && (oz_ff == OFS_MID);
   assign at_end    = (ox_ff == OFS_POS) && (oy_ff == OFS_POS) && (oz_ff == OFS_POS);
   assign issue     = (state_ff == S_WALK) && !at_center;
   assign nz_cur    = 2'(ox_ff != OFS_MID) + 2'(oy_ff != OFS_MID) + 2'(oz_ff != OFS_MID);

   assign center_s = $signed(LID_W'(center_ff));
   assign sx_s     = $signed(LID_W'(grid_x_ff));
   assign sxy_s    = $signed(LID_W'(sxy_ff));

   always_comb begin
      case (ox_ff)
         OFS_NEG: tx = '1;
         OFS_POS: tx = LID_W'(1);
         default: tx = '0;
      endcase
      case (oy_ff)
         OFS_NEG: ty = -sx_s;
         OFS_POS: ty = sx_s;
         default: ty = '0;
      endcase
      case (oz_ff)
         OFS_NEG: tz = -sxy_s;
         OFS_POS: tz = sxy_s;
         default: tz = '0;
      endcase
      id_sum = center_s + tx + ty + tz;
   end

   always_comb begin
      state_in = state_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      oz_in    = oz_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_cmd == CMD_EXPAND) begin
               state_in = S_SXY;
            end
         end
         S_SXY: state_in = S_TOT;
         S_TOT: begin
            state_in = S_WALK;
            ox_in    = OFS_NEG;
            oy_in    = OFS_NEG;
            oz_in    = OFS_NEG;
         end
         S_WALK: begin
            if (adv) begin
               if (at_end) begin
                  state_in = S_IDLE;
               end
               // z fastest, then y, then x
               if (oz_ff == OFS_POS) begin
                  oz_in = OFS_NEG;
                  if (oy_ff == OFS_POS) begin
                     oy_in = OFS_NEG;
                     ox_in = ox_ff + 2'd1;
                  end else begin
                     oy_in = oy_ff + 2'd1;
                  end
               end else begin
                  oz_in = oz_ff + 2'd1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ox_ff    <= OFS_NEG;
         oy_ff    <= OFS_NEG;
         oz_ff    <= OFS_NEG;
      end else begin
         state_ff <= state_in;
         ox_ff    <= ox_in;
         oy_ff    <= oy_in;
         oz_ff    <= oz_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && req_cmd == CMD_EXPAND) begin
         center_ff <= req_voxel_id;
      end
      if (state_ff == S_SXY) begin
         sxy_ff <= SXY_W'(grid_x_ff) * SXY_W'(grid_y_ff);
      end
      if (state_ff == S_TOT) begin
         total_ff <= TOT_W'(sxy_ff) * TOT_W'(grid_z_ff);
      end
   end

   // ---------------- address and store read stages ----------------
   assign s1_inr = !s1_id_ff[LID_W-1]
                   && (TOT_W'(s1_id_ff[LID_W-2:0]) < total_ff)
                   && (TOT_W'(s1_id_ff[LID_W-2:0]) < DEPTH_LIM);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_id_ff   <= id_sum;
         s1_nz_ff   <= nz_cur;
         s1_last_ff <= at_end;
         s2_inr_ff  <= s1_inr;
         s2_nid_ff  <= s1_inr ? s1_id_ff[ID_W-1:0] : '0;
         s2_nz_ff   <= s1_nz_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // loads only when no lookup is in flight
   assign ram_wr_en   = req_fire && (req_cmd == CMD_LOAD)
                        && (TOT_W'(req_voxel_id) < DEPTH_LIM);
   assign ram_wr_addr = VOXEL_AW'(req_voxel_id);
   assign ram_wr_data = {req_reachable_in, req_clearance_in};
   assign ram_rd_addr = s1_id_ff[VOXEL_AW-1:0];

   vnce_ram #(
      .WIDTH(ENT_W),
      .DEPTH(VOXEL_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (adv),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // ---------------- acceptance and divide ----------------
   assign s2_clr = ram_rd_data[CLR_W-1:0];
   assign s2_acc = s2_inr_ff && ram_rd_data[CLR_W]
                   && ($signed(s2_clr) > $signed({1'b0, cmin_ff}));

   assign div_side_in = '{nid: s2_nid_ff, acc: s2_acc, last: s2_last_ff};

   vnce_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (s2_valid_ff),
      .in_num   (step_num(s2_nz_ff)),
      .in_den   (s2_clr[DEN_W-1:0]),
      .in_side  (div_side_in),
      .out_valid(div_valid),
      .out_quo  (div_quo),
      .out_side (div_side_out)
   );

   always_comb begin
      if (!div_side_out.acc) begin
         cost_sat = '0;
      end else if (div_quo > NUM_W'(COST_MAX)) begin
         cost_sat = COST_MAX;
      end else begin
         cost_sat = div_quo[COST_W-1:0];
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_nid_ff  <= div_side_out.nid;
         rsp_cost_ff <= cost_sat;
         rsp_acc_ff  <= div_side_out.acc;
         rsp_last_ff <= div_side_out.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_neighbor_id = rsp_nid_ff;
   assign rsp_step_cost   = rsp_cost_ff;
   assign rsp_accepted    = rsp_acc_ff;
   assign rsp_last        = rsp_last_ff;

   // ---------------- assertions ----------------
   // a lookup only starts from the walk
   a_issue_from_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(s1_valid_ff) |-> $past(state_ff == S_WALK))
      else $error("lookup started outside the neighbor walk");

   // store writes never race pending reads
   a_write_no_lookup: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (!s1_valid_ff && !s2_valid_ff && state_ff == S_IDLE))
      else $error("store write while a lookup is in flight");

   // a rejected neighbor carries no cost
   a_reject_zero_cost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_accepted) |-> (rsp_step_cost == '0))
      else $error("rejected neighbor with nonzero cost");

   // clearance below 2^15 and step of at least 1.0 give a cost of at least 2
   a_accept_cost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> (rsp_step_cost > COST_W'(1)))
      else $error("accepted neighbor with cost below the minimum");

endmodule
